>>> hw/rtl/suffix_array_lcp_builder_defines.svh
// ----------------------------------------------------------------------------
// Suffix array / LCP builder assertion macros
// Shared clocking and reset for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SUFFIX_ARRAY_LCP_BUILDER_DEFINES_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_DEFINES_SVH

// property holds at every edge out of reset
`define SAL_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// cond at one edge implies nxt at the following edge
`define SAL_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

>>> hw/rtl/sal_pkg.sv
// ----------------------------------------------------------------------------
// Suffix array / LCP builder package
// Field widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

  localparam int SYM_W = 8;  // text symbol
  localparam int IDX_W = 6;  // suffix start / prefix length fields

  typedef enum logic [3:0] {
    ST_IDLE,   // loading symbols
    ST_KEYI,   // fetch key of suffix i
    ST_KEYL,   // latch key i, start scan
    ST_SCAN,   // compare key i against every key j
    ST_WRN,    // write new rank of i
    ST_COPY,   // new ranks -> rank copies
    ST_INV,    // rank -> order
    ST_LRD,    // LCP: fetch rank of i
    ST_LR,     // LCP: latch rank, fetch neighbor
    ST_LJ,     // LCP: latch neighbor start
    ST_LCI,    // LCP: fetch symbol pair
    ST_LCC,    // LCP: compare symbol pair
    ST_LWR,    // LCP: write length
    ST_ORD,    // output: fetch entry k
    ST_OSH,    // output: load output register
    ST_OWAIT   // output: wait for word to be taken
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/sal_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/suffix_array_lcp_builder.sv
// ----------------------------------------------------------------------------
// Suffix array / LCP builder
// Builds the suffix array and Kasai LCP array of a loaded byte string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o, symbol_i, last_symbol_i): one
//   symbol per word, one word per cycle while loading. Symbols past MAX_LEN
//   are dropped and set truncated_o for the run. last_symbol_i starts the
//   build; in_stall_o stays high from then until the last result is taken.
//   Output channel (out_valid_o / out_stall_i): n words in sorted order,
//   suffix_start_o, common_prefix_o (0 on the last), truncated_o,
//   last_result_o on the final word.
//   Ranking runs P passes (P <= log2(n) + 2), each bound by the single
//   read port of the rank RAMs (one key compare per cycle). LCP matching
//   compares at most 2n matched symbols. Output: each word passes the
//   fetch, load and wait states, and the next word is fetched only once
//   the previous one is taken.
//   A stalled output word holds; the sequencer simply waits.
//   Reset clears length, overflow flag and sequencer; RAM contents are
//   never cleared, only entries written for the current string are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "suffix_array_lcp_builder_defines.svh"

module suffix_array_lcp_builder #(
  parameter int MAX_LEN = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input words
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       last_symbol_i,
  // result words
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [5:0]      suffix_start_o,
  output logic [5:0]      common_prefix_o,
  output logic            truncated_o,
  output logic            last_result_o
);

  localparam int SymW = sal_pkg::SYM_W;
  localparam int IdxW = sal_pkg::IDX_W;
  localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;  // RAM address
  localparam int CW   = $clog2(MAX_LEN + 1);                  // counts up to n
  localparam int SW   = CW + 1;                               // index sums
  localparam int KW   = SymW + AW + 1;                        // sort key
  localparam logic [CW-1:0] LenMax = CW'(MAX_LEN);
  localparam logic [CW-1:0] CntOne = CW'(1);

  sal_pkg::state_e state_q, state_d;

  // control / datapath registers
  logic [CW-1:0] len_q, n_q, span_q, i_q, j_q, eq_q, c_q, h_q, k_q;
  logic          ovf_q, first_q, alldist_q, rd_v_q, rd_sv_q, cp_v_q;
  logic [KW-1:0] key_i_q;
  logic [AW-1:0] lt_q, cp_a_q, r_q, jj_q;
  logic [IdxW-1:0] out_start_q, out_lcp_q;
  logic          out_trunc_q, out_last_q, out_valid_q;

  // RAM ports
  logic            tx_we;
  logic [AW-1:0]   tx_waddr, txa_raddr, txb_raddr;
  logic [SymW-1:0] txa_rdata, txb_rdata;
  logic            rk_we, rkn_we, sa_we, lcp_we;
  logic [AW-1:0]   rk_waddr, rka_raddr, rkb_raddr, rkn_waddr, rkn_raddr;
  logic [AW-1:0]   rka_rdata, rkb_rdata, rkn_rdata;
  logic [AW-1:0]   sa_waddr, sa_wdata, sa_raddr, sa_rdata;
  logic [AW-1:0]   lcp_waddr, lcp_wdata, lcp_raddr, lcp_rdata;

  // derived
  logic          in_acc, out_acc, has_room;
  logic          issue, cp_issue, cp_done, i_last, k_last, r_tail, pair_ok, sym_eq;
  logic [CW-1:0] iss_addr;
  logic [SW-1:0] sec_sum, ih_sum, jh_sum;
  logic [SymW-1:0] prim;
  logic [AW:0]   sec;
  logic [KW-1:0] key_cur;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign has_room = len_q < LenMax;

  assign iss_addr = (state_q == sal_pkg::ST_KEYI) ? i_q : j_q;
  assign issue    = ((state_q == sal_pkg::ST_KEYL) || (state_q == sal_pkg::ST_SCAN))
                    && (j_q < n_q);
  assign cp_issue = ((state_q == sal_pkg::ST_COPY) || (state_q == sal_pkg::ST_INV))
                    && (c_q < n_q);
  assign cp_done  = (c_q == n_q) && !cp_v_q;
  assign i_last   = (i_q + CntOne) == n_q;
  assign k_last   = (k_q + CntOne) == n_q;
  assign r_tail   = CW'(rka_rdata) == (n_q - CntOne);

  // second half of the doubling key sits span positions further on
  assign sec_sum  = {1'b0, iss_addr} + {1'b0, span_q};
  assign prim     = first_q ? txa_rdata : SymW'(rka_rdata);
  assign sec      = rd_sv_q ? ((AW + 1)'(rkb_rdata) + (AW + 1)'(1)) : '0;
  assign key_cur  = {prim, sec};

  // Kasai compare positions
  assign ih_sum   = {1'b0, i_q} + {1'b0, h_q};
  assign jh_sum   = {1'b0, CW'(jj_q)} + {1'b0, h_q};
  assign pair_ok  = (ih_sum < {1'b0, n_q}) && (jh_sum < {1'b0, n_q});
  assign sym_eq   = txa_rdata == txb_rdata;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      sal_pkg::ST_IDLE:  if (in_acc && last_symbol_i) state_d = sal_pkg::ST_KEYI;
      sal_pkg::ST_KEYI:  state_d = sal_pkg::ST_KEYL;
      sal_pkg::ST_KEYL:  state_d = sal_pkg::ST_SCAN;
      sal_pkg::ST_SCAN:  if (!rd_v_q && (j_q == n_q)) state_d = sal_pkg::ST_WRN;
      sal_pkg::ST_WRN:   state_d = i_last ? sal_pkg::ST_COPY : sal_pkg::ST_KEYI;
      sal_pkg::ST_COPY: begin
        if (cp_done) state_d = alldist_q ? sal_pkg::ST_INV : sal_pkg::ST_KEYI;
      end
      sal_pkg::ST_INV:   if (cp_done) state_d = sal_pkg::ST_LRD;
      sal_pkg::ST_LRD:   state_d = sal_pkg::ST_LR;
      sal_pkg::ST_LR:    state_d = r_tail ? sal_pkg::ST_LWR : sal_pkg::ST_LJ;
      sal_pkg::ST_LJ:    state_d = sal_pkg::ST_LCI;
      sal_pkg::ST_LCI:   state_d = pair_ok ? sal_pkg::ST_LCC : sal_pkg::ST_LWR;
      sal_pkg::ST_LCC:   state_d = sym_eq ? sal_pkg::ST_LCI : sal_pkg::ST_LWR;
      sal_pkg::ST_LWR:   state_d = i_last ? sal_pkg::ST_ORD : sal_pkg::ST_LRD;
      sal_pkg::ST_ORD:   state_d = sal_pkg::ST_OSH;
      sal_pkg::ST_OSH:   state_d = sal_pkg::ST_OWAIT;
      sal_pkg::ST_OWAIT: begin
        if (out_acc) state_d = k_last ? sal_pkg::ST_IDLE : sal_pkg::ST_ORD;
      end
      default:           state_d = sal_pkg::ST_IDLE;
    endcase
  end

  // ---------------- memory controls ----------------
  always_comb begin
    in_stall_o = state_q != sal_pkg::ST_IDLE;

    tx_we     = (state_q == sal_pkg::ST_IDLE) && in_acc && has_room;
    tx_waddr  = len_q[AW-1:0];
    txa_raddr = (state_q == sal_pkg::ST_LCI) ? ih_sum[AW-1:0] : iss_addr[AW-1:0];
    txb_raddr = jh_sum[AW-1:0];

    rkb_raddr = sec_sum[AW-1:0];
    case (state_q)
      sal_pkg::ST_INV: rka_raddr = c_q[AW-1:0];
      sal_pkg::ST_LRD: rka_raddr = i_q[AW-1:0];
      default:         rka_raddr = iss_addr[AW-1:0];
    endcase
    rk_we     = (state_q == sal_pkg::ST_COPY) && cp_v_q;
    rk_waddr  = cp_a_q;

    rkn_we    = state_q == sal_pkg::ST_WRN;
    rkn_waddr = i_q[AW-1:0];
    rkn_raddr = c_q[AW-1:0];

    sa_we     = (state_q == sal_pkg::ST_INV) && cp_v_q;
    sa_waddr  = rka_rdata;
    sa_wdata  = cp_a_q;
    sa_raddr  = (state_q == sal_pkg::ST_LR) ? (rka_rdata + AW'(1)) : k_q[AW-1:0];

    lcp_we    = state_q == sal_pkg::ST_LWR;
    lcp_waddr = r_q;
    lcp_wdata = h_q[AW-1:0];
    lcp_raddr = k_q[AW-1:0];
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sal_pkg::ST_IDLE;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      first_q     <= 1'b1;
      span_q      <= '0;
      alldist_q   <= 1'b1;
      i_q         <= '0;
      j_q         <= '0;
      eq_q        <= '0;
      lt_q        <= '0;
      c_q         <= '0;
      h_q         <= '0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      rd_sv_q     <= 1'b0;
      cp_v_q      <= 1'b0;
      cp_a_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue;
      rd_sv_q <= !first_q && (sec_sum < {1'b0, n_q});
      cp_v_q  <= cp_issue;
      cp_a_q  <= c_q[AW-1:0];
      if (cp_issue) c_q <= c_q + CntOne;

      case (state_q)
        sal_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (!has_room) ovf_q <= 1'b1;
            if (last_symbol_i) begin
              n_q       <= has_room ? (len_q + CntOne) : len_q;
              len_q     <= '0;
              first_q   <= 1'b1;
              span_q    <= '0;
              alldist_q <= 1'b1;
              i_q       <= '0;
            end else if (has_room) begin
              len_q <= len_q + CntOne;
            end
          end
        end
        sal_pkg::ST_KEYI: begin
          j_q  <= '0;
          lt_q <= '0;
          eq_q <= '0;
        end
        sal_pkg::ST_KEYL: begin
          key_i_q <= key_cur;
          if (issue) j_q <= j_q + CntOne;
        end
        sal_pkg::ST_SCAN: begin
          if (issue) j_q <= j_q + CntOne;
          if (rd_v_q) begin
            if (key_cur < key_i_q)  lt_q <= lt_q + AW'(1);
            if (key_cur == key_i_q) eq_q <= eq_q + CntOne;
          end
        end
        sal_pkg::ST_WRN: begin
          if (eq_q != CntOne) alldist_q <= 1'b0;
          i_q <= i_q + CntOne;
          if (i_last) c_q <= '0;
        end
        sal_pkg::ST_COPY: begin
          if (cp_done) begin
            c_q <= '0;
            if (!alldist_q) begin
              i_q       <= '0;
              alldist_q <= 1'b1;
              first_q   <= 1'b0;
              span_q    <= first_q ? CntOne : (span_q << 1);
            end
          end
        end
        sal_pkg::ST_INV: begin
          if (cp_done) begin
            i_q <= '0;
            h_q <= '0;
          end
        end
        sal_pkg::ST_LR: begin
          r_q <= rka_rdata;
          if (r_tail) h_q <= '0;
        end
        sal_pkg::ST_LJ:  jj_q <= sa_rdata;
        sal_pkg::ST_LCC: if (sym_eq) h_q <= h_q + CntOne;
        sal_pkg::ST_LWR: begin
          if (h_q != '0) h_q <= h_q - CntOne;
          i_q <= i_q + CntOne;
          if (i_last) k_q <= '0;
        end
        sal_pkg::ST_OSH: out_valid_q <= 1'b1;
        sal_pkg::ST_OWAIT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            k_q         <= k_q + CntOne;
            if (k_last) ovf_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (state_q == sal_pkg::ST_OSH) begin
      out_start_q <= IdxW'(sa_rdata);
      out_lcp_q   <= IdxW'(lcp_rdata);
      out_trunc_q <= ovf_q;
      out_last_q  <= k_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign suffix_start_o  = out_start_q;
  assign common_prefix_o = out_lcp_q;
  assign truncated_o     = out_trunc_q;
  assign last_result_o   = out_last_q;

  // ---------------- memories ----------------
  // text, two copies for the two Kasai read positions
  sal_ram #(.Width(SymW), .Depth(MAX_LEN), .AddrW(AW)) u_txa (
    .clk_i, .we_i(tx_we), .waddr_i(tx_waddr), .wdata_i(symbol_i),
    .raddr_i(txa_raddr), .rdata_o(txa_rdata)
  );
  sal_ram #(.Width(SymW), .Depth(MAX_LEN), .AddrW(AW)) u_txb (
    .clk_i, .we_i(tx_we), .waddr_i(tx_waddr), .wdata_i(symbol_i),
    .raddr_i(txb_raddr), .rdata_o(txb_rdata)
  );
  // rank, two copies: key head and key tail read together
  sal_ram #(.Width(AW), .Depth(MAX_LEN), .AddrW(AW)) u_rka (
    .clk_i, .we_i(rk_we), .waddr_i(rk_waddr), .wdata_i(rkn_rdata),
    .raddr_i(rka_raddr), .rdata_o(rka_rdata)
  );
  sal_ram #(.Width(AW), .Depth(MAX_LEN), .AddrW(AW)) u_rkb (
    .clk_i, .we_i(rk_we), .waddr_i(rk_waddr), .wdata_i(rkn_rdata),
    .raddr_i(rkb_raddr), .rdata_o(rkb_rdata)
  );
  // ranks of the pass in progress
  sal_ram #(.Width(AW), .Depth(MAX_LEN), .AddrW(AW)) u_rkn (
    .clk_i, .we_i(rkn_we), .waddr_i(rkn_waddr), .wdata_i(lt_q),
    .raddr_i(rkn_raddr), .rdata_o(rkn_rdata)
  );
  // sorted suffix starts
  sal_ram #(.Width(AW), .Depth(MAX_LEN), .AddrW(AW)) u_sa (
    .clk_i, .we_i(sa_we), .waddr_i(sa_waddr), .wdata_i(sa_wdata),
    .raddr_i(sa_raddr), .rdata_o(sa_rdata)
  );
  // common prefix lengths by sorted rank
  sal_ram #(.Width(AW), .Depth(MAX_LEN), .AddrW(AW)) u_lcp (
    .clk_i, .we_i(lcp_we), .waddr_i(lcp_waddr), .wdata_i(lcp_wdata),
    .raddr_i(lcp_raddr), .rdata_o(lcp_rdata)
  );

  // ---------------- assertions ----------------
  `SAL_ASSERT_HOLDS(a_len_cap, len_q <= LenMax, "stored length beyond capacity")
  `SAL_ASSERT_HOLDS(a_lcp_bound, (state_q == sal_pkg::ST_LCC) |-> (h_q < n_q), "lcp run past n")
  `SAL_ASSERT_NEXT(a_last_idle, out_acc && out_last_q, state_q == sal_pkg::ST_IDLE, "no idle after run")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Suffix array / LCP builder testbench
// Streams byte strings into the builder and checks every sorted suffix word
// (start, common prefix, truncated, last) against a behavioral prediction.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_LEN    = 64;
  localparam int IDLE_LIMIT = 150000;

  typedef struct packed {
    logic [5:0] start;
    logic [5:0] lcp;
    logic       trunc;
    logic       last;
  } suffix_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] symbol_i;
  logic       last_symbol_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [5:0] suffix_start_o;
  logic [5:0] common_prefix_o;
  logic       truncated_o;
  logic       last_result_o;

  // predictor copy of the text buffer
  logic [7:0]   text_buf [MAX_LEN];
  int           text_len;
  bit           text_dropped;
  suffix_word_t sorted_q [$];

  int errors;
  int words_checked;
  int symbols_sent;
  int strings_sent;
  int idle_cycles;
  int send_idle_pct;   // 0 gives a stretch with no sender gaps
  int recv_stall_pct;  // 0 gives a stretch with no receiver stalls
  int hold_request;    // long receiver hold-off, in cycles

  suffix_array_lcp_builder #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .symbol_i       (symbol_i),
    .last_symbol_i  (last_symbol_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .suffix_start_o (suffix_start_o),
    .common_prefix_o(common_prefix_o),
    .truncated_o    (truncated_o),
    .last_result_o  (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction: plain suffix comparison. A suffix that is a prefix of another
  // sorts first; the common prefix is measured directly against the next one.
  // ---------------------------------------------------------------------------
  function automatic bit suffix_before(int a, int b, int n);
    int k;
    for (k = 0; a + k < n && b + k < n; k++) begin
      if (text_buf[a+k] != text_buf[b+k]) return text_buf[a+k] < text_buf[b+k];
    end
    return (a + k) >= n;  // a ran out first
  endfunction

  function automatic int common_run(int a, int b, int n);
    int h;
    h = 0;
    while (a + h < n && b + h < n && text_buf[a+h] == text_buf[b+h]) h++;
    return h;
  endfunction

  task automatic predict_sorted_suffixes();
    int           order [MAX_LEN];
    int           i;
    int           j;
    int           cur;
    suffix_word_t w;
    for (i = 0; i < text_len; i++) order[i] = i;
    for (i = 1; i < text_len; i++) begin
      cur = order[i];
      j   = i;
      while (j > 0 && suffix_before(cur, order[j-1], text_len)) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (i = 0; i < text_len; i++) begin
      w.start = order[i][5:0];
      w.lcp   = (i + 1 < text_len) ? 6'(common_run(order[i], order[i+1], text_len)) : 6'd0;
      w.trunc = text_dropped;
      w.last  = (i + 1 == text_len);
      sorted_q.insert(sorted_q.size(), w);
    end
    text_len     = 0;
    text_dropped = 1'b0;
  endtask

  // Channels are sampled mid-cycle; inputs only move at the rising edge, so
  // a word seen here valid and unstalled is taken at the next edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (text_len < MAX_LEN) begin
          text_buf[text_len] = symbol_i;
          text_len++;
        end else begin
          text_dropped = 1'b1;  // capacity exceeded: symbol dropped
        end
        if (last_symbol_i) predict_sorted_suffixes();
      end
    end
  end

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH @%0t %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // result checker
  always @(negedge clk_i) begin
    suffix_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (sorted_q.size() == 0) begin
        report("unexpected word, start", 8'(suffix_start_o), 8'd0);
      end else begin
        want = sorted_q.pop_front();
        if (suffix_start_o !== want.start)
          report("suffix_start", 8'(suffix_start_o), 8'(want.start));
        if (common_prefix_o !== want.lcp)
          report("common_prefix", 8'(common_prefix_o), 8'(want.lcp));
        if (truncated_o !== want.trunc)
          report("truncated", 8'(truncated_o), 8'(want.trunc));
        if (last_result_o !== want.last)
          report("last_result", 8'(last_result_o), 8'(want.last));
      end
    end
  end

  // watchdog: cycles in which neither channel moves a word
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a word, %0d results pending",
                 idle_cycles, sorted_q.size());
        $display("suffix_array_lcp_builder verification failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, rare long ones, and a requested hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    int hold_left;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      hold_left   = 0;
    end else begin
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (recv_stall_pct > 0 && $urandom_range(199) == 0) begin
        hold_left = $urandom_range(40, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic int sender_gap();
    int roll;
    if (send_idle_pct == 0) return 0;
    roll = $urandom_range(99);
    if (roll >= send_idle_pct) return 0;
    if (roll < 4) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // Called at a rising edge; returns at the edge that takes the word.
  task automatic send_word(logic [7:0] sym, logic last);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    symbol_i      <= sym;
    last_symbol_i <= last;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    symbols_sent++;
    if (last) strings_sent++;
  endtask

  // alphabet 0 means full byte range, else symbols from a small set near base
  task automatic send_string(int len, int alphabet);
    logic [7:0] base;
    int         i;
    base = 8'($urandom_range(255));
    for (i = 0; i < len; i++) begin
      if (alphabet == 0) send_word(8'($urandom_range(255)), i == len - 1);
      else send_word(base + 8'($urandom_range(alphabet - 1)), i == len - 1);
    end
  endtask

  task automatic send_text(logic [7:0] txt [$]);
    int i;
    for (i = 0; i < txt.size(); i++) send_word(txt[i], i == txt.size() - 1);
  endtask

  // sender goes quiet until every expected word is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sorted_q.size() != 0);
  endtask

  // edge symbols, repeats, a classic periodic text, sorted and reversed runs
  task automatic test_directed();
    send_text('{8'h00});
    send_text('{8'hff});
    send_text('{8'h00, 8'hff});
    send_text('{8'hff, 8'h00});
    send_text('{8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61});
    send_text('{8'h62, 8'h61, 8'h6e, 8'h61, 8'h6e, 8'h61});
    send_text('{8'h80, 8'h40, 8'h20, 8'h10});
    wait_drained();
  endtask

  // full buffer, one symbol dropped, last symbol itself dropped
  task automatic test_capacity();
    send_string(MAX_LEN, 2);
    send_string(MAX_LEN + 1, 0);
    send_string(MAX_LEN + 3, 1);
    wait_drained();
  endtask

  task automatic test_random(int budget);
    int len;
    while (budget > 0) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      send_string(len, ($urandom_range(2) == 0) ? 0 : $urandom_range(3, 1));
      budget -= len;
      if ($urandom_range(9) == 0) begin
        send_idle_pct  = ($urandom_range(2) == 0) ? 0 : 30;
        recv_stall_pct = ($urandom_range(2) == 0) ? 0 : 30;
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    hold_request = 600;
    send_string(5, 2);
    send_string(3, 0);
    send_string(4, 1);
    wait_drained();  // sender pauses until all words are back
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    symbol_i       = 8'h00;
    last_symbol_i  = 1'b0;
    text_len       = 0;
    text_dropped   = 1'b0;
    errors         = 0;
    words_checked  = 0;
    symbols_sent   = 0;
    strings_sent   = 0;
    idle_cycles    = 0;
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    hold_request   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_capacity();
    test_backpressure();
    test_random(70);
    wait_drained();
    test_random(60);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d strings, %0d symbols, %0d suffix words checked",
             strings_sent, symbols_sent, words_checked);
    $display("including full and overflowing buffers and a long output hold-off");
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("suffix_array_lcp_builder verification clean");
    end else begin
      $display("suffix_array_lcp_builder verification failed");
    end
    $finish;
  end

endmodule
